>>> rtl/tvvi_pkg.sv
// shared types and constants for the tiled volume voxel index block
// no dependencies; imported by the top level, the checker and the testbench
package tvvi_pkg;

    // stream and config port widths
    localparam int S_TDATA_W  = 136;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    // rotation entry: cosine in the low half, sine in the high half
    localparam int          ROT_W        = 32;
    localparam logic [31:0] ROT_IDENTITY = 32'h0000_4000;

    // z upper bound, 1.0 in q15.16
    localparam logic [30:0] Z_ONE = 31'd65536;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_WRITE  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILES_X  = 4'd0,
        CFG_TILES_Y  = 4'd1,
        CFG_GRID_X   = 4'd2,
        CFG_GRID_Y   = 4'd3,
        CFG_GRID_Z   = 4'd4,
        CFG_SCALE_X  = 4'd5,
        CFG_SCALE_Y  = 4'd6,
        CFG_CENTER   = 4'd7
    } t_cfg_reg;

endpackage

>>> rtl/tvvi_ram.sv
// generic single write port, single read port ram with registered read
// no package dependencies
module tvvi_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tiled_volume_voxel_index.sv
// a lookup beat passes through stage registers a to f; its result is offered from stage f
// throughput: one beat per cycle; each stage holds its item on a stall, bubbles fill
// reset clears config to defaults, then sweeps the rotation table to identity,
// one entry per cycle over all MAX_TILES entries, with input tready low meanwhile
// config writes are taken in every cycle, including during the sweep
module tiled_volume_voxel_index #(
    parameter int MAX_TILES    = 256,
    parameter int MAX_GRID_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tvvi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tvvi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], entry_tile[103:96],
    // entry_cos[119:104], entry_sin[135:120]
    input  logic [tvvi_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd[0]
    input  logic [tvvi_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    // result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // voxel_index[29:0], tile_id[37:30], zero pad[39:38]
    output logic [tvvi_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // inside_res[0]
    output logic [tvvi_pkg::M_TUSER_W-1:0]  o_m_axis_tuser
);
    import tvvi_pkg::*;

    localparam int TA    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int DIM_W = $clog2(MAX_GRID_DIM + 1);
    localparam int ZP_W  = 17 + DIM_W;
    localparam int TW    = 2 * DIM_W;
    localparam int PW    = 3 * DIM_W;
    localparam int LW    = 28;
    localparam int PRW   = 44;
    localparam int GW    = 46;

    // ---------------------------------------------------------------
    // config registers
    logic [4:0]  r_tiles_x, r_tiles_y;
    logic [10:0] r_grid_x, r_grid_y, r_grid_z, r_scale_x, r_scale_y;
    logic [19:0] r_center_xy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_x   <= 5'd1;
            r_tiles_y   <= 5'd1;
            r_grid_x    <= 11'd1;
            r_grid_y    <= 11'd1;
            r_grid_z    <= 11'd1;
            r_scale_x   <= 11'd1;
            r_scale_y   <= 11'd1;
            r_center_xy <= 20'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TILES_X: r_tiles_x   <= i_cfg_data[4:0];
                CFG_TILES_Y: r_tiles_y   <= i_cfg_data[4:0];
                CFG_GRID_X:  r_grid_x    <= i_cfg_data[10:0];
                CFG_GRID_Y:  r_grid_y    <= i_cfg_data[10:0];
                CFG_GRID_Z:  r_grid_z    <= i_cfg_data[10:0];
                CFG_SCALE_X: r_scale_x   <= i_cfg_data[10:0];
                CFG_SCALE_Y: r_scale_y   <= i_cfg_data[10:0];
                CFG_CENTER:  r_center_xy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // grid size of zero reads as one, oversize reads as the maximum
    function automatic logic [DIM_W-1:0] dim_of(input logic [10:0] g);
        logic [DIM_W-1:0] d;
        if (g == 11'd0) begin
            d = DIM_W'(1);
        end else if (32'(g) > 32'(MAX_GRID_DIM)) begin
            d = DIM_W'(MAX_GRID_DIM);
        end else begin
            d = DIM_W'(g);
        end
        return d;
    endfunction

    // floor of a q.30 value, clamped to [0, d-1]
    function automatic logic [DIM_W-1:0] clamp_coord(input logic signed [GW-1:0] g,
                                                     input logic [DIM_W-1:0]     d);
        logic [15:0]      fl;
        logic [DIM_W-1:0] dm1;
        logic [DIM_W-1:0] c;
        fl  = g[GW-1-:16];
        dm1 = d - 1'b1;
        if (fl[15]) begin
            c = '0;
        end else if ({1'b0, fl[14:0]} > 16'(dm1)) begin
            c = dm1;
        end else begin
            c = DIM_W'(fl[14:0]);
        end
        return c;
    endfunction

    logic [DIM_W-1:0] dim_x, dim_y, dim_z;
    assign dim_x = dim_of(r_grid_x);
    assign dim_y = dim_of(r_grid_y);
    assign dim_z = dim_of(r_grid_z);

    // ---------------------------------------------------------------
    // stage enables: a stage loads when it is empty or its item moves on
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v;
    logic en_a, en_b, en_c, en_d, en_e, en_f;
    logic r_clr_busy;
    logic [TA-1:0] r_clr_addr;

    assign en_f = !r_f_v || i_m_axis_tready;
    assign en_e = !r_e_v || en_f;
    assign en_d = !r_d_v || en_e;
    assign en_c = !r_c_v || en_d;
    assign en_b = !r_b_v || en_c;
    assign en_a = !r_a_v || en_b;

    assign o_s_axis_tready = en_a && !r_clr_busy;

    // ---------------------------------------------------------------
    // stage a: input register
    t_cmd               r_a_cmd;
    logic signed [31:0] r_a_pos_x, r_a_pos_y, r_a_pos_z;
    logic [7:0]         r_a_tile;
    logic [15:0]        r_a_cos, r_a_sin;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_cmd   <= t_cmd'(i_s_axis_tuser[0]);
            r_a_pos_x <= i_s_axis_tdata[31:0];
            r_a_pos_y <= i_s_axis_tdata[63:32];
            r_a_pos_z <= i_s_axis_tdata[95:64];
            r_a_tile  <= i_s_axis_tdata[103:96];
            r_a_cos   <= i_s_axis_tdata[119:104];
            r_a_sin   <= i_s_axis_tdata[135:120];
        end
    end

    // tile select and bounds
    logic                    bx_ok, by_ok, z_ok, bid_ok, a_inside;
    logic [9:0]              a_bid;
    logic signed [15:0]      a_fx, a_fy;
    logic signed [LW-1:0]    a_lx, a_ly;
    logic [ZP_W-1:0]         a_zprod;
    logic                    item_wr, ram_we, ram_re;
    logic [TA-1:0]           ram_waddr;
    logic [ROT_W-1:0]        ram_wdata, ram_rdata;

    assign bx_ok  = !r_a_pos_x[31] && (r_a_pos_x[31:16] < 16'(r_tiles_x));
    assign by_ok  = !r_a_pos_y[31] && (r_a_pos_y[31:16] < 16'(r_tiles_y));
    assign z_ok   = !r_a_pos_z[31] && (r_a_pos_z[30:0] <= Z_ONE);
    assign a_bid  = 10'(r_a_pos_y[20:16]) * 10'(r_tiles_x) + 10'(r_a_pos_x[20:16]);
    assign bid_ok = 32'(a_bid) < 32'(MAX_TILES);
    assign a_inside = bx_ok && by_ok && z_ok && bid_ok;

    // in-tile fraction minus one half, as signed q.16
    assign a_fx = {~r_a_pos_x[15], r_a_pos_x[14:0]};
    assign a_fy = {~r_a_pos_y[15], r_a_pos_y[14:0]};
    assign a_lx = a_fx * $signed({1'b0, r_scale_x});
    assign a_ly = a_fy * $signed({1'b0, r_scale_y});
    assign a_zprod = r_a_pos_z[16:0] * dim_z;

    // rotation table port: clear sweep owns the write port after reset
    assign item_wr = r_a_v && (r_a_cmd == CMD_WRITE) && en_b &&
                     (32'(r_a_tile) < 32'(MAX_TILES));
    assign ram_re  = r_a_v && (r_a_cmd == CMD_LOOKUP) && en_b;
    assign ram_we  = r_clr_busy || item_wr;
    assign ram_waddr = r_clr_busy ? r_clr_addr : TA'(r_a_tile);
    assign ram_wdata = r_clr_busy ? ROT_IDENTITY : {r_a_sin, r_a_cos};

    tvvi_ram #(
        .WIDTH (ROT_W),
        .DEPTH (MAX_TILES)
    ) u_rot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (TA'(a_bid)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == TA'(MAX_TILES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage b: scaled local coords, z product, rotation read
    logic                 r_b_inside;
    logic [7:0]           r_b_tile;
    logic signed [LW-1:0] r_b_lx, r_b_ly;
    logic [ZP_W-1:0]      r_b_zprod;

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_inside <= a_inside;
            r_b_tile   <= a_bid[7:0];
            r_b_lx     <= a_lx;
            r_b_ly     <= a_ly;
            r_b_zprod  <= a_zprod;
        end
    end

    logic signed [15:0] b_cos, b_sin;
    logic [DIM_W:0]     b_zi;
    logic [DIM_W-1:0]   b_iz, dzm1;

    assign b_cos = ram_rdata[15:0];
    assign b_sin = ram_rdata[31:16];
    assign b_zi  = r_b_zprod[ZP_W-1:16];
    assign dzm1  = dim_z - 1'b1;
    assign b_iz  = (b_zi > (DIM_W+1)'(dzm1)) ? dzm1 : DIM_W'(b_zi);

    // ---------------------------------------------------------------
    // stage c: rotation products
    logic                  r_c_inside;
    logic [7:0]            r_c_tile;
    logic signed [PRW-1:0] r_c_pcx, r_c_psy, r_c_psx, r_c_pcy;
    logic [DIM_W-1:0]      r_c_iz;

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_inside <= r_b_inside;
            r_c_tile   <= r_b_tile;
            r_c_pcx    <= b_cos * r_b_lx;
            r_c_psy    <= b_sin * r_b_ly;
            r_c_psx    <= b_sin * r_b_lx;
            r_c_pcy    <= b_cos * r_b_ly;
            r_c_iz     <= b_iz;
        end
    end

    // sum, add center (q.30), floor and clamp
    logic signed [GW-1:0] c_gx, c_gy;

    assign c_gx = GW'(r_c_pcx) - GW'(r_c_psy) + $signed({6'b0, r_center_xy[9:0], 30'b0});
    assign c_gy = GW'(r_c_psx) + GW'(r_c_pcy) + $signed({6'b0, r_center_xy[19:10], 30'b0});

    // ---------------------------------------------------------------
    // stage d: grid coordinates
    logic             r_d_inside;
    logic [7:0]       r_d_tile;
    logic [DIM_W-1:0] r_d_ix, r_d_iy, r_d_iz;

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_inside <= r_c_inside;
            r_d_tile   <= r_c_tile;
            r_d_ix     <= clamp_coord(c_gx, dim_x);
            r_d_iy     <= clamp_coord(c_gy, dim_y);
            r_d_iz     <= r_c_iz;
        end
    end

    // ---------------------------------------------------------------
    // stage e: iz*dim_y + iy
    logic             r_e_inside;
    logic [7:0]       r_e_tile;
    logic [TW-1:0]    r_e_t;
    logic [DIM_W-1:0] r_e_ix;
    logic [TW-1:0]    d_t;

    assign d_t = TW'(r_d_iz) * TW'(dim_y) + TW'(r_d_iy);

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_inside <= r_d_inside;
            r_e_tile   <= r_d_tile;
            r_e_t      <= d_t;
            r_e_ix     <= r_d_ix;
        end
    end

    // ---------------------------------------------------------------
    // stage f: output register, outside points read as zero
    logic [PW-1:0]           e_idx;
    logic [M_TDATA_W-1:0]    r_f_data;
    logic                    r_f_inside;

    assign e_idx = PW'(r_e_t) * PW'(dim_x) + PW'(r_e_ix);

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_f_inside <= r_e_inside;
            r_f_data   <= r_e_inside ? {2'b00, r_e_tile, 30'(e_idx)} : '0;
        end
    end

    assign o_m_axis_tvalid = r_f_v;
    assign o_m_axis_tdata  = r_f_data;
    assign o_m_axis_tuser  = r_f_inside;

    // ---------------------------------------------------------------
    // valid bits; write beats drop out after stage a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_s_axis_tvalid && o_s_axis_tready;
            if (en_b) r_b_v <= r_a_v && (r_a_cmd == CMD_LOOKUP);
            if (en_c) r_c_v <= r_b_v;
            if (en_d) r_d_v <= r_c_v;
            if (en_e) r_e_v <= r_d_v;
            if (en_f) r_f_v <= r_e_v;
        end
    end

    // ---------------------------------------------------------------
    // checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_s_axis_tready)
        else $error("input beat taken during rotation table sweep");

    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("rotation table read and written in the same cycle");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("outside result carries a nonzero index");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_busy && (r_clr_addr == TA'(MAX_TILES - 1))) |=> !r_clr_busy)
        else $error("rotation table sweep did not end at the last entry");

endmodule

>>> verif/tvvi_checker.sv
// checker for the tiled volume voxel index block: watches the config, input and
// result channels, keeps its own copy of the registers and the rotation table,
// predicts each lookup result and compares it; depends on tvvi_pkg
module tvvi_checker #(
    parameter int MAX_TILES    = 256,
    parameter int MAX_GRID_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [tvvi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tvvi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [tvvi_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [tvvi_pkg::S_TUSER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [tvvi_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  logic [tvvi_pkg::M_TUSER_W-1:0]  i_m_tuser,
    output logic [31:0]                     o_fail_count,
    output logic [31:0]                     o_pending,
    output logic [31:0]                     o_checked
);
    import tvvi_pkg::*;

    typedef struct packed {
        logic        in_vol;
        logic [29:0] vidx;
        logic [7:0]  tile;
    } t_voxel_res;

    logic [4:0]       tiles_x, tiles_y;
    logic [10:0]      grid_x, grid_y, grid_z;
    logic [10:0]      scale_x, scale_y;
    logic [19:0]      center_xy;
    logic [ROT_W-1:0] tile_rot [MAX_TILES];

    t_voxel_res expected_voxels [$];
    t_voxel_res want, got;
    int         fails   = 0;
    int         checked = 0;

    function automatic longint grid_dim(input logic [10:0] g);
        if (g == 0) return 1;
        if (g > MAX_GRID_DIM) return MAX_GRID_DIM;
        return longint'(g);
    endfunction

    function automatic longint clamp_dim(input longint v, input longint hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_voxel_res predict_voxel(input logic [31:0] x, y, z);
        longint           px, py, pz, bx, by, bid, c, s, lx, ly, gx, gy;
        longint           dx, dy, dz, ix, iy, iz, idx;
        logic [ROT_W-1:0] rot;
        t_voxel_res       r;
        r  = '0;
        px = longint'($signed(x));
        py = longint'($signed(y));
        pz = longint'($signed(z));
        bx = px >>> 16;
        by = py >>> 16;
        if (bx < 0 || bx >= longint'(tiles_x) || by < 0 || by >= longint'(tiles_y) ||
            pz < 0 || pz > longint'(Z_ONE))
            return r;
        bid = by * longint'(tiles_x) + bx;
        if (bid >= MAX_TILES)
            return r;
        rot = tile_rot[bid[7:0]];
        c   = longint'($signed(rot[15:0]));
        s   = longint'($signed(rot[31:16]));
        // in-tile fraction minus one half, q.16 times the tile scale
        lx  = (longint'(x[15:0]) - 32768) * longint'(scale_x);
        ly  = (longint'(y[15:0]) - 32768) * longint'(scale_y);
        // rotation in q.30, center shifted up to match
        gx  = c * lx - s * ly + (longint'(center_xy[9:0]) << 30);
        gy  = s * lx + c * ly + (longint'(center_xy[19:10]) << 30);
        dx  = grid_dim(grid_x);
        dy  = grid_dim(grid_y);
        dz  = grid_dim(grid_z);
        ix  = clamp_dim(gx >>> 30, dx - 1);
        iy  = clamp_dim(gy >>> 30, dy - 1);
        iz  = clamp_dim((pz * dz) >>> 16, dz - 1);
        idx = (iz * dy + iy) * dx + ix;
        r.in_vol = 1'b1;
        r.vidx   = idx[29:0];
        r.tile   = bid[7:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tiles_x   = 5'd1;
            tiles_y   = 5'd1;
            grid_x    = 11'd1;
            grid_y    = 11'd1;
            grid_z    = 11'd1;
            scale_x   = 11'd1;
            scale_y   = 11'd1;
            center_xy = '0;
            for (int i = 0; i < MAX_TILES; i++)
                tile_rot[i] = ROT_IDENTITY;
            expected_voxels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_TILES_X: tiles_x   = i_cfg_data[4:0];
                    CFG_TILES_Y: tiles_y   = i_cfg_data[4:0];
                    CFG_GRID_X:  grid_x    = i_cfg_data[10:0];
                    CFG_GRID_Y:  grid_y    = i_cfg_data[10:0];
                    CFG_GRID_Z:  grid_z    = i_cfg_data[10:0];
                    CFG_SCALE_X: scale_x   = i_cfg_data[10:0];
                    CFG_SCALE_Y: scale_y   = i_cfg_data[10:0];
                    CFG_CENTER:  center_xy = i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_cmd'(i_s_tuser[0]) == CMD_WRITE) begin
                    if (i_s_tdata[103:96] < MAX_TILES)
                        tile_rot[i_s_tdata[103:96]] = {i_s_tdata[135:120], i_s_tdata[119:104]};
                end else begin
                    expected_voxels.push_back(predict_voxel(i_s_tdata[31:0],
                                                            i_s_tdata[63:32],
                                                            i_s_tdata[95:64]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.in_vol = i_m_tuser[0];
                got.vidx   = i_m_tdata[29:0];
                got.tile   = i_m_tdata[37:30];
                if (expected_voxels.size() == 0) begin
                    fails++;
                    $display("%0t: result beat with no lookup pending,", $time);
                    $display("    got in_vol=%0b index=%0d tile=%0d",
                             got.in_vol, got.vidx, got.tile);
                end else begin
                    want = expected_voxels.pop_front();
                    checked++;
                    if (want.in_vol !== got.in_vol || want.vidx !== got.vidx ||
                        want.tile !== got.tile) begin
                        fails++;
                        $display("%0t: voxel mismatch, expected in_vol=%0b index=%0d tile=%0d,",
                                 $time, want.in_vol, want.vidx, want.tile);
                        $display("    got in_vol=%0b index=%0d tile=%0d",
                                 got.in_vol, got.vidx, got.tile);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_voxels.size();
        o_checked    <= checked;
    end

endmodule

>>> verif/tb_top.sv
// top of the tiled volume voxel index testbench: clock, reset, config writes,
// lookup and rotation-write stimulus, result-side stalls and the verdict;
// depends on tvvi_pkg, tiled_volume_voxel_index and tvvi_checker
module tb_top;
    import tvvi_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 100;
    // no register behind this index, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd15;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cfg_ready;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic [31:0]           fail_count, pending, checked;

    int   lookups_sent  = 0;
    int   writes_sent   = 0;
    int   settings_used = 0;
    int   cur_tx        = 1;
    int   cur_ty        = 1;
    logic send_burst    = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tiled_volume_voxel_index dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    tvvi_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [19:0] tx, ty, gx, gy, gz, sx, sy, ctr);
        cfg_write(CFG_TILES_X, tx);
        cfg_write(CFG_TILES_Y, ty);
        cfg_write(CFG_GRID_X, gx);
        cfg_write(CFG_GRID_Y, gy);
        cfg_write(CFG_GRID_Z, gz);
        cfg_write(CFG_SCALE_X, sx);
        cfg_write(CFG_SCALE_Y, sy);
        cfg_write(CFG_CENTER, ctr);
        cur_tx = int'(tx[4:0]);
        cur_ty = int'(ty[4:0]);
        settings_used++;
    endtask

    task automatic send_beat(input t_cmd cmd, input logic [31:0] x, y, z,
                             input logic [7:0] tile, input logic [15:0] cs, sn);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sn, cs, tile, z, y, x};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_WRITE)
            writes_sent++;
        else
            lookups_sent++;
    endtask

    task automatic send_lookup(input logic [31:0] x, y, z);
        send_beat(CMD_LOOKUP, x, y, z, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_entry(input logic [7:0] tile, input logic [15:0] cs, sn);
        send_beat(CMD_WRITE, $urandom, $urandom, $urandom, tile, cs, sn);
    endtask

    // waits until every lookup has its result, then lets the pipe settle
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_trig;
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, 32768) - 16384);
        return 16'($urandom);
    endfunction

    // mostly a tile inside the grid with a random fraction, some edge tiles and noise
    function automatic logic [31:0] rand_coord(input int tiles);
        int          pick;
        logic [15:0] whole;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom;
        if (pick == 1)
            whole = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'(tiles);
        else
            whole = 16'($urandom_range(0, (tiles > 0) ? tiles - 1 : 0));
        return {whole, 16'($urandom)};
    endfunction

    function automatic logic [31:0] rand_depth;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return $urandom;
        if (pick == 2) begin
            case ($urandom_range(0, 2))
                0:       return 32'd0;
                1:       return 32'(Z_ONE);
                default: return 32'(Z_ONE) + 32'd1;
            endcase
        end
        return $urandom_range(0, 65536);
    endfunction

    task automatic random_item;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            send_entry(8'($urandom_range(0, 255)), rand_trig(), rand_trig());
        else
            send_lookup(rand_coord(cur_tx), rand_coord(cur_ty), rand_depth());
    endtask

    // result side: random stalls, bursts, and two long hold-offs
    initial begin
        int   taken;
        int   stall;
        logic rx_burst;
        taken    = 0;
        rx_burst = 1'b0;
        @(posedge clk);
        forever begin
            if (taken == 150 || taken == 560) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles, %0d lookups still pending",
                 $time, WATCHDOG_LIMIT, pending);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int phase;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 4x3 tiles, small grid, off-center
        set_config(20'd4, 20'd3, 20'd64, 20'd32, 20'd16, 20'd40, 20'd20, {10'd16, 10'd32});
        cfg_write(CFG_SPARE_IDX, 20'hFFFFF);
        send_entry(8'd0, 16'h0000, 16'h4000);
        send_entry(8'd5, 16'hC000, 16'h0000);
        send_entry(8'd11, 16'h7FFF, 16'h8000);
        send_entry(8'd255, 16'($urandom), 16'($urandom));
        send_lookup(32'h0000_0000, 32'h0000_0000, 32'd0);
        send_lookup(32'h0000_FFFF, 32'h0000_FFFF, 32'(Z_ONE));
        send_lookup(32'h0001_8000, 32'h0001_4000, 32'h0000_8000);
        send_lookup(32'h0000_8000, 32'h0000_8000, 32'(Z_ONE) + 32'd1);
        send_lookup(32'h0000_8000, 32'h0000_8000, 32'hFFFF_FFFF);
        send_lookup(32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_4000);
        send_lookup(32'h0004_0000, 32'h0000_8000, 32'h0000_4000);
        send_lookup(32'h0003_FFFF, 32'h0002_FFFF, 32'h0000_C000);
        send_lookup(32'h8000_0000, 32'h0000_8000, 32'h0000_4000);
        send_lookup(32'h7FFF_FFFF, 32'h0000_8000, 32'h0000_4000);
        send_lookup(32'h0000_8000, 32'h8000_0000, 32'h0000_4000);
        send_lookup(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        wait_idle();

        // zero tile count puts everything outside
        set_config(20'd0, 20'd3, 20'd64, 20'd32, 20'd16, 20'd40, 20'd20, 20'd0);
        send_lookup(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_lookup(32'h0000_0000, 32'h0000_0000, 32'd0);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_config(20'd16, 20'd16, 20'd1024, 20'd1024, 20'd1024,
                              20'd1024, 20'd1024, 20'hFFFFF);
                1: set_config(20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd0);
                // grid 0 and scale 0: single-cell grid, tile collapses on the center
                2: set_config(20'd4, 20'd4, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
                              20'($urandom));
                // every data bit set: oversized tile grid and grid dims
                3: set_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                              20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
                4: set_config(20'd2, 20'd16, 20'd1024, 20'd2, 20'd1024, 20'd512, 20'd3,
                              20'($urandom));
                default: set_config(20'($urandom_range(1, 16)), 20'($urandom_range(1, 16)),
                                    20'($urandom_range(1, 1024)), 20'($urandom_range(1, 1024)),
                                    20'($urandom_range(1, 1024)), 20'($urandom_range(0, 2047)),
                                    20'($urandom_range(0, 2047)), 20'($urandom));
            endcase
            repeat (ITEMS_PER_PHASE) random_item();
            wait_idle();
        end

        $display("run covered %0d lookups and %0d rotation writes over %0d register settings",
                 lookups_sent, writes_sent, settings_used);
        $display("%0d voxel results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
